>>> rtl/aitb_pkg.sv
// Package for the ASCII numeral to bytes converter: payload structs, status
// and register codes, and constant helpers for width and byte order.
// No dependencies.
package aitb_pkg;

  localparam int MAX_BITS_DEFAULT = 64;

  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] CH_UPPER_X = 8'h58;  // 'X'

  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] BASE_DEC   = 5'd10;
  localparam logic [4:0] BASE_HEX   = 5'd16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_BASE = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_WIDTH_SELECT   = 1'b0,
    CFG_BIG_ENDIAN_OUT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [63:0] packed_bytes;
    status_t     status;
  } result_item_t;

  // Width code actually in force: halve 8 << ws until it fits max_bits.
  function automatic logic [1:0] eff_code(logic [1:0] ws, int max_bits);
    logic [1:0] c;
    c = ws;
    for (int i = 0; i < 3; i++) begin
      if (((8 << c) > max_bits) && (c != 2'd0)) begin
        c = c - 2'd1;
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] mask64(logic [1:0] code);
    logic [63:0] m;
    if (code == 2'd3) begin
      m = '1;
    end else begin
      m = (64'd1 << (8 << code)) - 64'd1;
    end
    return m;
  endfunction

  // Reverse the low (1 << code) bytes of v; bytes above are zero.
  function automatic logic [63:0] byte_swap(logic [63:0] v, logic [1:0] code);
    logic [63:0] r;
    int          nb;
    r  = '0;
    nb = 1 << code;
    for (int k = 0; k < 8; k++) begin
      if (k < nb) begin
        r[8*k +: 8] = v[8*(nb-1-k) +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/ascii_integer_to_bytes.sv
// ASCII numeral to bytes converter, top level.
// Depends on aitb_pkg (types, codes, width and byte-order helpers).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  char     | char_valid / char_stall   | char_data   : ch[7:0], last
//  result   | result_valid/result_stall | result_data : packed_bytes[63:0],
//           |                           |               status[1:0]
//  cfg      | cfg_write (no wait)       | cfg_index[0], cfg_data[1:0]
//
// One character per cycle while char_stall is low. The per-character step (x10 or x16
// plus digit, overflow compare against a per-width limit) sits between the
// numeral state registers; a result is registered from the post-step state of its last char.
// The result side has an output register plus one skid entry, so a char is
// taken while a finished result waits; char_stall rises only when both are
// occupied. Synchronous reset clears the numeral state, the result buffer
// and the config registers (width 64 bits, little-endian).
module ascii_integer_to_bytes #(
  parameter int MAX_BITS = aitb_pkg::MAX_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  aitb_pkg::char_item_t   char_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output aitb_pkg::result_item_t result_data,
  input  logic                   cfg_write,
  input  aitb_pkg::cfg_index_t   cfg_index,
  input  logic [1:0]             cfg_data
);

  localparam int ACC_W = MAX_BITS;

  // width_select -> width code in force under MAX_BITS
  localparam logic [3:0][1:0] EFF_TAB = {
    aitb_pkg::eff_code(2'd3, MAX_BITS), aitb_pkg::eff_code(2'd2, MAX_BITS),
    aitb_pkg::eff_code(2'd1, MAX_BITS), aitb_pkg::eff_code(2'd0, MAX_BITS)
  };
  // per width code: value mask and decimal limit (max / 10)
  localparam logic [3:0][63:0] MASK_TAB = {
    aitb_pkg::mask64(2'd3), aitb_pkg::mask64(2'd2),
    aitb_pkg::mask64(2'd1), aitb_pkg::mask64(2'd0)
  };
  localparam logic [3:0][63:0] DEC_TAB = {
    aitb_pkg::mask64(2'd3) / 10, aitb_pkg::mask64(2'd2) / 10,
    aitb_pkg::mask64(2'd1) / 10, aitb_pkg::mask64(2'd0) / 10
  };

  // config registers
  logic [1:0] width_select;
  logic       big_endian_out;

  // numeral state
  logic [ACC_W-1:0]  accum, accum_next;
  logic [1:0]        char_count, char_count_next;
  logic              hex_mode, hex_mode_next;
  logic              prefix_pending, prefix_pending_next;
  aitb_pkg::status_t error_code, error_code_next;

  // result buffer: output register plus skid entry
  logic                   skid_valid;
  aitb_pkg::result_item_t skid_data;

  logic                   char_take;
  logic                   result_pop;
  logic                   result_push;
  aitb_pkg::result_item_t result_new;

  // step datapath
  logic [1:0]        code;
  logic [ACC_W-1:0]  mask;
  logic [ACC_W-1:0]  dec_lim;
  logic [ACC_W-1:0]  acc_m;
  logic [ACC_W-1:0]  acc_step;
  logic [ACC_W-1:0]  digit_ext;
  logic [4:0]        digit;
  logic              is_x;
  logic              take_prefix;
  aitb_pkg::status_t step_err;
  logic [63:0]       value64;

  assign char_stall = skid_valid;
  assign char_take  = char_valid && !char_stall;
  assign result_pop = result_valid && !result_stall;

  assign code    = EFF_TAB[width_select];
  assign mask    = MASK_TAB[code][ACC_W-1:0];
  assign dec_lim = DEC_TAB[code][ACC_W-1:0];
  assign acc_m   = accum & mask;

  // character classification
  always_comb begin
    if (char_data.ch >= aitb_pkg::CH_ZERO && char_data.ch <= aitb_pkg::CH_NINE) begin
      digit = 5'(char_data.ch - aitb_pkg::CH_ZERO);
    end else if (char_data.ch >= aitb_pkg::CH_LOWER_A &&
                 char_data.ch <= aitb_pkg::CH_LOWER_F) begin
      digit = 5'(char_data.ch - aitb_pkg::CH_LOWER_A) + 5'd10;
    end else if (char_data.ch >= aitb_pkg::CH_UPPER_A &&
                 char_data.ch <= aitb_pkg::CH_UPPER_F) begin
      digit = 5'(char_data.ch - aitb_pkg::CH_UPPER_A) + 5'd10;
    end else begin
      digit = aitb_pkg::DIGIT_NONE;
    end
  end

  assign is_x = (char_data.ch == aitb_pkg::CH_LOWER_X) ||
                (char_data.ch == aitb_pkg::CH_UPPER_X);
  // "0x" only counts as a prefix if more characters follow
  assign take_prefix = (char_count == 2'd1) && prefix_pending && is_x && !char_data.last;

  assign digit_ext = ACC_W'(digit[3:0]);

  // value*base + digit; x10 as two shifted adds, wraps at ACC_W then masked
  always_comb begin
    if (hex_mode) begin
      acc_step = {acc_m[ACC_W-5:0], 4'b0000} | digit_ext;
    end else begin
      acc_step = {acc_m[ACC_W-4:0], 3'b000} + {acc_m[ACC_W-2:0], 1'b0} + digit_ext;
    end
    acc_step = acc_step & mask;
  end

  always_comb begin
    if (digit == aitb_pkg::DIGIT_NONE) begin
      step_err = aitb_pkg::STATUS_BAD_CHAR;
    end else if (digit >= (hex_mode ? aitb_pkg::BASE_HEX : aitb_pkg::BASE_DEC)) begin
      step_err = aitb_pkg::STATUS_BAD_BASE;
    end else if (hex_mode && (acc_m > (mask >> 4))) begin
      step_err = aitb_pkg::STATUS_OVERFLOW;
    end else if (!hex_mode && (acc_m > dec_lim)) begin
      step_err = aitb_pkg::STATUS_OVERFLOW;
    end else begin
      step_err = aitb_pkg::STATUS_OK;
    end
  end

  // numeral state update; first error sticks until the last character
  always_comb begin
    accum_next          = acc_m;
    hex_mode_next       = hex_mode;
    prefix_pending_next = prefix_pending;
    error_code_next     = error_code;
    char_count_next     = (char_count == 2'd3) ? char_count : char_count + 2'd1;
    if (error_code == aitb_pkg::STATUS_OK) begin
      if (take_prefix) begin
        hex_mode_next = 1'b1;
        accum_next    = '0;
      end else if (step_err != aitb_pkg::STATUS_OK) begin
        error_code_next = step_err;
      end else begin
        accum_next = acc_step;
      end
      prefix_pending_next = (char_count == 2'd0) && (char_data.ch == aitb_pkg::CH_ZERO);
    end
  end

  // result formed from the post-step state
  assign value64 = 64'(accum_next);
  always_comb begin
    result_new.status = error_code_next;
    if (error_code_next != aitb_pkg::STATUS_OK) begin
      result_new.packed_bytes = '0;
    end else if (big_endian_out) begin
      result_new.packed_bytes = aitb_pkg::byte_swap(value64, code);
    end else begin
      result_new.packed_bytes = value64;
    end
  end

  assign result_push = char_take && char_data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select   <= 2'd3;
      big_endian_out <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aitb_pkg::CFG_WIDTH_SELECT:   width_select   <= cfg_data;
        aitb_pkg::CFG_BIG_ENDIAN_OUT: big_endian_out <= cfg_data[0];
        default:                      width_select   <= width_select;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum          <= '0;
      char_count     <= 2'd0;
      hex_mode       <= 1'b0;
      prefix_pending <= 1'b0;
      error_code     <= aitb_pkg::STATUS_OK;
    end else if (char_take) begin
      if (char_data.last) begin
        accum          <= '0;
        char_count     <= 2'd0;
        hex_mode       <= 1'b0;
        prefix_pending <= 1'b0;
        error_code     <= aitb_pkg::STATUS_OK;
      end else begin
        accum          <= accum_next;
        char_count     <= char_count_next;
        hex_mode       <= hex_mode_next;
        prefix_pending <= prefix_pending_next;
        error_code     <= error_code_next;
      end
    end
  end

  // output register and skid entry; a push never meets a full skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_pop) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        result_data  <= skid_data;
        skid_valid   <= 1'b0;
      end else if (result_push) begin
        result_valid <= 1'b1;
        result_data  <= result_new;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (result_push) begin
      skid_valid <= 1'b1;
      skid_data  <= result_new;
    end
  end

endmodule

>>> verif/aitb_checker.sv
// Checker for the ASCII numeral to bytes converter: watches the char, result
// and register ports, predicts each result and compares it field by field.
// Depends on aitb_pkg for payload types, status and register codes.
`timescale 1ns / 1ps

module aitb_checker
  import aitb_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  input  logic         char_stall,
  input  char_item_t   char_data,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_item_t result_data,
  input  logic         cfg_write,
  input  cfg_index_t   cfg_index,
  input  logic [1:0]   cfg_data,
  output int           mismatches,
  output int           results_owed
);

  // register mirror
  logic [1:0]   width_code;
  logic         big_endian;

  // numeral in progress
  logic [63:0]  run_value;
  logic [1:0]   char_seen;      // saturates at 3
  logic         hex_base;
  logic         lead_zero;
  status_t      first_err;

  result_item_t conversions_due[$];
  int           mismatch_total = 0;

  task automatic start_numeral();
    run_value = '0;
    char_seen = '0;
    hex_base  = 1'b0;
    lead_zero = 1'b0;
    first_err = STATUS_OK;
  endtask

  // Append one predicted result behind those already owed.
  task automatic owe_result(input result_item_t r);
    conversions_due = {conversions_due, r};
  endtask

  // One char into the running value; on last, queue the result it yields.
  task automatic convert_char(input char_item_t item);
    int unsigned  bits;
    int unsigned  nbytes;
    int unsigned  pos;
    logic [63:0]  mask;
    logic [63:0]  radix;
    logic [63:0]  packed_val;
    logic [4:0]   dig;
    result_item_t due_item;

    bits = 8 << width_code;
    while (bits > MAX_BITS && bits > 8) bits = bits >> 1;
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    run_value = run_value & mask;

    if (first_err == STATUS_OK) begin
      if (char_seen == 2'd1 && lead_zero && !item.last &&
          (item.ch == CH_LOWER_X || item.ch == CH_UPPER_X)) begin
        hex_base  = 1'b1;
        run_value = '0;
      end else begin
        if (item.ch >= CH_ZERO && item.ch <= CH_NINE) begin
          dig = 5'(item.ch - CH_ZERO);
        end else if (item.ch >= CH_LOWER_A && item.ch <= CH_LOWER_F) begin
          dig = 5'(item.ch - CH_LOWER_A + 8'd10);
        end else if (item.ch >= CH_UPPER_A && item.ch <= CH_UPPER_F) begin
          dig = 5'(item.ch - CH_UPPER_A + 8'd10);
        end else begin
          dig = DIGIT_NONE;
        end
        radix = hex_base ? 64'd16 : 64'd10;
        if (dig == DIGIT_NONE) begin
          first_err = STATUS_BAD_CHAR;
        end else if (64'(dig) >= radix) begin
          first_err = STATUS_BAD_BASE;
        end else if (hex_base && run_value > (mask >> 4)) begin
          first_err = STATUS_OVERFLOW;
        end else if (!hex_base && run_value > mask / 64'd10) begin
          first_err = STATUS_OVERFLOW;
        end else begin
          run_value = (run_value * radix + 64'(dig)) & mask;
        end
      end
      lead_zero = (char_seen == 2'd0 && item.ch == CH_ZERO);
    end
    if (char_seen != 2'd3) char_seen = char_seen + 2'd1;

    if (item.last) begin
      packed_val = '0;
      nbytes     = bits / 8;
      if (first_err == STATUS_OK) begin
        for (int k = 0; k < 8; k++) begin
          if (k < nbytes) begin
            pos = big_endian ? (nbytes - 1 - k) : k;
            packed_val[8*pos +: 8] = run_value[8*k +: 8];
          end
        end
      end
      due_item = '{packed_bytes: packed_val, status: first_err};
      owe_result(due_item);
      start_numeral();
    end
  endtask

  task automatic check_result(input result_item_t got);
    result_item_t want;
    if (conversions_due.size() == 0) begin
      $display("%0t: result with none owed: packed_bytes %h status %0d",
               $time, got.packed_bytes, got.status);
      mismatch_total++;
    end else begin
      want = conversions_due.pop_front();
      if (got.packed_bytes !== want.packed_bytes) begin
        $display("%0t: packed_bytes expected %h, got %h",
                 $time, want.packed_bytes, got.packed_bytes);
        mismatch_total++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        mismatch_total++;
      end
    end
  endtask

  // Results accepted at an edge belong to chars taken at earlier edges,
  // so the compare runs before this edge's char is folded in. A register
  // write at an edge applies from the next char on.
  always @(posedge clk) begin
    if (rst) begin
      width_code = 2'd3;
      big_endian = 1'b0;
      start_numeral();
      conversions_due.delete();
    end else begin
      if (result_valid && !result_stall) check_result(result_data);
      if (char_valid && !char_stall) convert_char(char_data);
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH_SELECT:   width_code = cfg_data;
          CFG_BIG_ENDIAN_OUT: big_endian = cfg_data[0];
          default: ;
        endcase
      end
    end
    results_owed <= conversions_due.size();
    mismatches   <= mismatch_total;
  end

endmodule

>>> verif/ascii_integer_to_bytes_tb.sv
// Testbench top for the ASCII numeral to bytes converter: clock, reset,
// char stimulus, result-side stall, register writes, watchdog and verdict.
// Depends on aitb_pkg, ascii_integer_to_bytes and aitb_checker.
`timescale 1ns / 1ps

module ascii_integer_to_bytes_tb;
  import aitb_pkg::*;

  localparam int MAX_BITS      = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off, fills the skid
  localparam int QUIET_LIMIT   = 1000;  // idle cycles before the watchdog trips
  localparam int PHASE_CHARS   = 205;

  logic         clk;
  logic         rst;
  logic         char_valid;
  logic         char_stall;
  char_item_t   char_data;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_data;
  logic         cfg_write;
  cfg_index_t   cfg_index;
  logic [1:0]   cfg_data;

  int           mismatches;
  int           results_owed;

  // stimulus knobs; the receiver process reads stalls_on and hold_go
  logic         stalls_on = 1'b0;
  logic         hold_go   = 1'b0;
  bit           gaps_on;
  logic [1:0]   cur_width;
  int           chars_sent;

  ascii_integer_to_bytes #(
    .MAX_BITS(MAX_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_data   (char_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  aitb_checker #(
    .MAX_BITS(MAX_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_data   (char_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side. One long hold-off when asked (counted here), otherwise
  // random stall bursts while stalls_on is set.
  int  stall_left;
  bit  hold_taken;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
      hold_taken   <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      result_stall <= 1'b1;
      stall_left   <= HOLD_CYCLES - 1;
      hold_taken   <= 1'b1;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One char transfer. Valid stays up between back-to-back chars; a random
  // gap drops it first. Returns once char_stall reads low after an edge.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{ch: c, last: fin};
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Drop valid, wait for every owed result, then give a char that produced
  // no result time to finish inside the block.
  task automatic settle();
    char_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a proper digit; now and then a stray byte or a letter that is
  // too big for a decimal numeral.
  function automatic logic [7:0] pick_char(input bit hex);
    int unsigned r;
    if ($urandom_range(0, 39) == 0) return 8'($urandom_range(0, 255));
    if (!hex && $urandom_range(0, 39) == 0) return 8'(CH_LOWER_A + $urandom_range(0, 5));
    r = $urandom_range(0, hex ? 15 : 9);
    if (r < 10) return 8'(CH_ZERO + r);
    if ($urandom_range(0, 1) != 0) return 8'(CH_LOWER_A + r - 10);
    return 8'(CH_UPPER_A + r - 10);
  endfunction

  // Lengths run up to two digits past what the width holds, so both the
  // wrap inside the decimal check and the overflow status come up often.
  task automatic send_random_numeral();
    int unsigned kind;
    int unsigned len;
    int unsigned dec_max;
    int unsigned hex_max;
    kind    = $urandom_range(0, 9);
    dec_max = (cur_width == 2'd0) ? 3 : (cur_width == 2'd1) ? 5 :
              (cur_width == 2'd2) ? 10 : 20;
    hex_max = 2 << cur_width;
    if (kind < 5) begin
      len = $urandom_range(1, dec_max + 2);
      for (int i = 0; i < len; i++) send_char(pick_char(1'b0), i == len - 1);
    end else if (kind < 8) begin
      send_char(CH_ZERO, 1'b0);
      send_char(($urandom_range(0, 1) != 0) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
      len = $urandom_range(1, hex_max + 2);
      for (int i = 0; i < len; i++) send_char(pick_char(1'b1), i == len - 1);
    end else begin
      // raw bytes, every bit of ch toggles here
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int          start;
    logic [1:0]  ws;
    logic        be;

    rst        = 1'b1;
    char_valid = 1'b0;
    char_data  = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_WIDTH_SELECT;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    cur_width  = 2'd3;
    chars_sent = 0;
    repeat (6) @(posedge clk);
    rst       <= 1'b0;
    stalls_on <= 1'b1;

    // Directed, reset settings (64 bits, little-endian): lone prefix,
    // byte extremes, upper-case prefix with mixed-case digits, a letter in
    // a decimal numeral followed by chars that must be ignored.
    send_text("0x", 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("0XfF", 1'b1);
    send_text("1a9", 1'b1);

    // 8 bits: 256 wraps past the decimal check, 2550 and 0x100 overflow
    settle();
    write_reg(CFG_WIDTH_SELECT, 2'd0);
    cur_width = 2'd0;
    send_text("256", 1'b1);
    send_text("2550", 1'b1);
    send_text("0x100", 1'b1);

    // Width narrowed mid-numeral: 276 at 16 bits truncates to 20 at 8 bits,
    // then the 5 gives 205.
    settle();
    write_reg(CFG_WIDTH_SELECT, 2'd1);
    send_text("276", 1'b0);
    settle();
    write_reg(CFG_WIDTH_SELECT, 2'd0);
    send_text("5", 1'b1);

    // Random phases: each width in both byte orders; the last two phases
    // run with no idling on either side.
    for (int p = 0; p < 8; p++) begin
      ws = 2'((p * 3 + 3) % 4);
      be = (p % 2 == 1) ^ (p >= 4);
      settle();
      write_reg(CFG_WIDTH_SELECT, ws);
      write_reg(CFG_BIG_ENDIAN_OUT, {1'($urandom_range(0, 1)), be});
      cur_width = ws;
      gaps_on   = (p < 6);
      stalls_on <= (p < 6);

      if (p == 3) begin
        // back-pressure: receiver holds off while one-char numerals keep
        // coming, so the output buffer fills and char_stall rises
        gaps_on = 1'b0;
        hold_go <= 1'b1;
        for (int i = 0; i < 24; i++) send_char(8'(CH_ZERO + i % 10), 1'b1);
        gaps_on = 1'b1;
      end

      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_numeral();
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/aitb_pkg.sv
rtl/ascii_integer_to_bytes.sv
verif/aitb_checker.sv
verif/ascii_integer_to_bytes_tb.sv
